### rtl/core/jmsp_pkg.sv
`default_nettype none
package jmsp_pkg;

   localparam int QUANT_ENTRIES = 64;
   localparam int ENTRY_COUNT_W = $clog2(QUANT_ENTRIES + 1);
   localparam int ENTRY_INDEX_W = 6;
   localparam int QUEUE_DEPTH   = 4;
   localparam int RSP_DATA_W    = 80;

   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] MK_SOI   = 8'hD8;
   localparam logic [7:0] MK_APP0  = 8'hE0;
   localparam logic [7:0] MK_EOI   = 8'hD9;
   localparam logic [7:0] MK_DQT   = 8'hDB;
   localparam logic [7:0] MK_SOS   = 8'hDA;
   localparam logic [7:0] MK_TEM   = 8'h01;
   localparam logic [3:0] MAX_TABLE_ID = 4'd3;

   typedef enum logic [2:0] {
      EV_MARKER    = 3'd0,
      EV_FRAME     = 3'd1,
      EV_QUANT     = 3'd2,
      EV_BAD_START = 3'd3,
      EV_END_IMAGE = 3'd4,
      EV_SCAN      = 3'd5,
      EV_BAD_TABLE = 3'd6
   } event_type;

   typedef enum logic [9:0] {
      PH_SOI_FF  = 10'b00_0000_0001,
      PH_SOI_M   = 10'b00_0000_0010,
      PH_APP_FF  = 10'b00_0000_0100,
      PH_APP_M   = 10'b00_0000_1000,
      PH_LEN_HI  = 10'b00_0001_0000,
      PH_LEN_LO  = 10'b00_0010_0000,
      PH_PAYLOAD = 10'b00_0100_0000,
      PH_SEEK    = 10'b00_1000_0000,
      PH_MARK    = 10'b01_0000_0000,
      PH_HALT    = 10'b10_0000_0000
   } phase_type;

   // one classified input word
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       is_ff;
      logic       is_standalone;
      logic       is_sof;
      logic       is_dqt;
      logic       is_eoi;
      logic       is_sos;
   } item_type;

   typedef struct packed {
      event_type  kind;
      logic [7:0] marker_code;
      logic [7:0] precision;
      logic [15:0] height;
      logic [15:0] width;
      logic [7:0] components;
      logic [3:0] table_id;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [7:0] entry_value;
   } result_type;

endpackage
`default_nettype wire

### rtl/core/jmsp_front.sv
`default_nettype none
module jmsp_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic [0:0]        req_tuser,
   input  wire logic              q_full,
   output logic                   q_push,
   output jmsp_pkg::item_type     q_item
);

   logic [7:0] b;

   assign b          = req_tdata;
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item               = '0;
      q_item.data          = b;
      q_item.first         = req_tuser[0];
      q_item.is_ff         = (b == jmsp_pkg::BYTE_FF);
      q_item.is_dqt        = (b == jmsp_pkg::MK_DQT);
      q_item.is_eoi        = (b == jmsp_pkg::MK_EOI);
      q_item.is_sos        = (b == jmsp_pkg::MK_SOS);
      q_item.is_standalone = (b == jmsp_pkg::MK_SOI) || (b == jmsp_pkg::MK_TEM)
                             || (b[7:3] == 5'b11010);
      case (b) inside
         8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
         8'hC9, 8'hCA, 8'hCB: q_item.is_sof = 1'b1;
         default:             q_item.is_sof = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/jmsp_queue.sv
`default_nettype none
module jmsp_queue #(
   parameter int DEPTH = jmsp_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jmsp_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output jmsp_pkg::item_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jmsp_pkg::item_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### rtl/core/jmsp_back.sv
`default_nettype none
module jmsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire jmsp_pkg::item_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output jmsp_pkg::result_type    rsp_result
);

   localparam int TC_W = jmsp_pkg::ENTRY_COUNT_W;

   jmsp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [7:0]  marker_ff, marker_in;
   logic        seg_sof_ff, seg_sof_in, seg_dqt_ff, seg_dqt_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] count_ff, count_in;
   logic [TC_W-1:0] tec_ff, tec_in;
   logic [3:0]  table_ff, table_in;
   logic [7:0]  prec_ff, prec_in;
   logic [15:0] height_ff, height_in, width_ff, width_in;
   logic        out_valid_ff, out_valid_in;
   jmsp_pkg::result_type out_ff, out_in, res;
   logic        emit;
   logic [7:0]  b;
   logic [15:0] seg_len;

   assign b         = q_head.data;
   assign q_pop     = q_valid && (!out_valid_ff || rsp_ready);
   assign cur_phase = q_head.first ? jmsp_pkg::PH_SOI_FF : phase_ff;
   assign seg_len   = {len_hi_ff, b};
   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      phase_in   = phase_ff;
      marker_in  = marker_ff;
      seg_sof_in = seg_sof_ff;
      seg_dqt_in = seg_dqt_ff;
      len_hi_in  = len_hi_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      tec_in     = tec_ff;
      table_in   = table_ff;
      prec_in    = prec_ff;
      height_in  = height_ff;
      width_in   = width_ff;
      emit       = 1'b0;
      res        = '0;

      unique case (cur_phase)
         jmsp_pkg::PH_SOI_FF, jmsp_pkg::PH_APP_FF: begin
            if (!q_head.is_ff) begin
               phase_in = jmsp_pkg::PH_HALT;
               emit     = 1'b1;
               res.kind = jmsp_pkg::EV_BAD_START;
            end else begin
               phase_in = (cur_phase == jmsp_pkg::PH_SOI_FF) ? jmsp_pkg::PH_SOI_M
                                                              : jmsp_pkg::PH_APP_M;
            end
         end
         jmsp_pkg::PH_SOI_M: begin
            emit = 1'b1;
            if (b != jmsp_pkg::MK_SOI) begin
               phase_in = jmsp_pkg::PH_HALT;
               res.kind = jmsp_pkg::EV_BAD_START;
            end else begin
               phase_in        = jmsp_pkg::PH_APP_FF;
               res.kind        = jmsp_pkg::EV_MARKER;
               res.marker_code = b;
            end
         end
         jmsp_pkg::PH_APP_M: begin
            emit = 1'b1;
            if (b != jmsp_pkg::MK_APP0) begin
               phase_in = jmsp_pkg::PH_HALT;
               res.kind = jmsp_pkg::EV_BAD_START;
            end else begin
               phase_in        = jmsp_pkg::PH_LEN_HI;
               marker_in       = b;
               seg_sof_in      = 1'b0;
               seg_dqt_in      = 1'b0;
               res.kind        = jmsp_pkg::EV_MARKER;
               res.marker_code = b;
            end
         end
         jmsp_pkg::PH_LEN_HI: begin
            len_hi_in = b;
            phase_in  = jmsp_pkg::PH_LEN_LO;
         end
         jmsp_pkg::PH_LEN_LO: begin
            limit_in = seg_len - 16'd2;
            count_in = '0;
            tec_in   = '0;
            phase_in = (seg_len <= 16'd2) ? jmsp_pkg::PH_SEEK : jmsp_pkg::PH_PAYLOAD;
         end
         jmsp_pkg::PH_PAYLOAD: begin
            count_in = count_ff + 16'd1;
            if (seg_sof_ff) begin
               case (count_ff)
                  16'd0: prec_in          = b;
                  16'd1: height_in[15:8]  = b;
                  16'd2: height_in[7:0]   = b;
                  16'd3: width_in[15:8]   = b;
                  16'd4: width_in[7:0]    = b;
                  16'd5: begin
                     emit            = 1'b1;
                     res.kind        = jmsp_pkg::EV_FRAME;
                     res.marker_code = marker_ff;
                     res.precision   = prec_ff;
                     res.height      = height_ff;
                     res.width       = width_ff;
                     res.components  = b;
                  end
                  default: ;
               endcase
            end else if (seg_dqt_ff) begin
               if (tec_ff == '0) begin
                  table_in = b[3:0];
                  tec_in   = TC_W'(1);
                  if (b[3:0] > jmsp_pkg::MAX_TABLE_ID) begin
                     emit            = 1'b1;
                     res.kind        = jmsp_pkg::EV_BAD_TABLE;
                     res.marker_code = marker_ff;
                     res.table_id    = b[3:0];
                  end
               end else begin
                  if (table_ff <= jmsp_pkg::MAX_TABLE_ID) begin
                     emit            = 1'b1;
                     res.kind        = jmsp_pkg::EV_QUANT;
                     res.marker_code = marker_ff;
                     res.table_id    = table_ff;
                     res.entry_index = jmsp_pkg::ENTRY_INDEX_W'(tec_ff - TC_W'(1));
                     res.entry_value = b;
                  end
                  tec_in = (tec_ff == TC_W'(jmsp_pkg::QUANT_ENTRIES)) ? '0
                                                                      : tec_ff + TC_W'(1);
               end
            end
            if (count_in >= limit_ff) begin
               phase_in = jmsp_pkg::PH_SEEK;
            end
         end
         jmsp_pkg::PH_SEEK: begin
            if (q_head.is_ff) begin
               phase_in = jmsp_pkg::PH_MARK;
            end
         end
         jmsp_pkg::PH_MARK: begin
            if (!q_head.is_ff) begin
               emit            = 1'b1;
               res.marker_code = b;
               if (q_head.is_eoi) begin
                  phase_in = jmsp_pkg::PH_HALT;
                  res.kind = jmsp_pkg::EV_END_IMAGE;
               end else if (q_head.is_sos) begin
                  phase_in = jmsp_pkg::PH_HALT;
                  res.kind = jmsp_pkg::EV_SCAN;
               end else if (q_head.is_standalone) begin
                  phase_in = jmsp_pkg::PH_SEEK;
                  res.kind = jmsp_pkg::EV_MARKER;
               end else begin
                  phase_in   = jmsp_pkg::PH_LEN_HI;
                  marker_in  = b;
                  seg_sof_in = q_head.is_sof;
                  seg_dqt_in = q_head.is_dqt;
                  res.kind   = jmsp_pkg::EV_MARKER;
               end
            end
         end
         jmsp_pkg::PH_HALT: ;
         default: phase_in = jmsp_pkg::PH_HALT;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (q_pop) begin
         out_valid_in = emit;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jmsp_pkg::PH_SOI_FF;
         count_ff     <= '0;
         limit_ff     <= '0;
         tec_ff       <= '0;
         seg_sof_ff   <= 1'b0;
         seg_dqt_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            limit_ff   <= limit_in;
            tec_ff     <= tec_in;
            seg_sof_ff <= seg_sof_in;
            seg_dqt_ff <= seg_dqt_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         marker_ff <= marker_in;
         len_hi_ff <= len_hi_in;
         table_ff  <= table_in;
         prec_ff   <= prec_in;
         height_ff <= height_in;
         width_ff  <= width_in;
      end
      out_ff <= out_in;
   end

   // payload phase always has at least one byte left to count
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jmsp_pkg::PH_PAYLOAD |-> count_ff < limit_ff)
      else $error("payload count reached segment limit without leaving payload");

   a_quant_id: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == jmsp_pkg::EV_QUANT |->
         out_ff.table_id <= jmsp_pkg::MAX_TABLE_ID)
      else $error("quant entry reported for an invalid table id");

   a_halt_after_stop: assert property (@(posedge clock) disable iff (reset)
      q_pop && emit && (res.kind == jmsp_pkg::EV_BAD_START ||
                        res.kind == jmsp_pkg::EV_END_IMAGE ||
                        res.kind == jmsp_pkg::EV_SCAN)
      |=> phase_ff == jmsp_pkg::PH_HALT)
      else $error("parser did not halt after a stop event");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("pending result word lost or changed");

endmodule
`default_nettype wire

### rtl/core/jpeg_marker_segment_parser_core.sv
`default_nettype none
// channel   dir  ports                          word
// req       in   req_tvalid/tready/tdata/tuser  one file byte, tuser = first byte of file
// rsp       out  rsp_tvalid/tready/tdata/tuser  one parse event, tuser = event kind
//
// one byte per cycle sustained while rsp is not held off; the parse state machine in the back end
// decides each byte combinationally and holds its result in one output register
// a small byte queue sits between the classifier and the parser, so req stalls
// only when the queue fills while rsp is held off
// a byte waits at the queue head while a result word is held off, even if it gives no event
// reset: synchronous, active high; empties the queue and rearms the start check
module jpeg_marker_segment_parser_core #(
   parameter int QUEUE_DEPTH = jmsp_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic [0:0]  req_tuser,   // first_byte[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // marker_code[7:0], precision[15:8], height[31:16], width[47:32],
   // components[55:48], table_id[59:56], entry_index[65:60], entry_value[73:66], zeros
   output logic [jmsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]       rsp_tuser    // event_res[2:0]
);

   jmsp_pkg::item_type   push_item, head;
   jmsp_pkg::result_type result;
   logic q_full, q_push, q_pop, q_valid;

   jmsp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   jmsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (head)
   );

   jmsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {6'd0, result.entry_value, result.entry_index, result.table_id,
                       result.components, result.width, result.height,
                       result.precision, result.marker_code};

endmodule
`default_nettype wire
